### rtl/spdcrc_pkg.sv
// shared types, constants and the byte-wide crc-16/xmodem update for the
// spd image checker; no dependencies
`default_nettype none

package spdcrc_pkg;

  localparam int COUNT_W = 11;
  localparam int CRC_W   = 16;
  localparam int CFG_W   = 11;

  localparam logic [COUNT_W-1:0] COUNT_SAT     = 11'd1025;
  localparam logic [CRC_W-1:0]   CRC_POLY      = 16'h1021;
  localparam logic [COUNT_W-1:0] MIN_SIZE_RST  = 11'd256;
  localparam logic [7:0]         DDR5_TYPE_RST = 8'd18;

  typedef enum logic [0:0] {
    REG_MIN_SIZE  = 1'b0,
    REG_DDR5_TYPE = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_SIZE      = 3'd1,
    ERR_TYPE      = 3'd2,
    ERR_CRC_SHORT = 3'd3,
    ERR_CRC_MISS  = 3'd4
  } err_code_t;

  typedef struct packed {
    logic             image_ok;
    logic [2:0]       error_code;
    logic [CRC_W-1:0] computed_crc;
  } result_t;

  // msb-first crc over one byte, eight shift steps
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [7:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/spdcrc_accum.sv
// per-image state: byte count, running crc, latched header fields, and the
// verdict on the final byte; uses spdcrc_pkg
`default_nettype none

module spdcrc_accum #(
  parameter int TYPE_OFFSET = 2,
  parameter int CRC_OFFSET  = 510
) (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  take,
  input  wire  [7:0]                           data_byte,
  input  wire                                  last,
  input  wire  [spdcrc_pkg::CFG_W-1:0]         min_size,
  input  wire  [7:0]                           ddr5_type_code,
  output spdcrc_pkg::result_t                  verdict
);
  import spdcrc_pkg::*;

  localparam logic [COUNT_W-1:0] TYPE_POS = COUNT_W'(TYPE_OFFSET);
  localparam logic [COUNT_W-1:0] CRC_POS  = COUNT_W'(CRC_OFFSET);
  localparam logic [COUNT_W-1:0] CRC_HI   = COUNT_W'(CRC_OFFSET + 1);
  localparam logic [COUNT_W-1:0] CRC_END  = COUNT_W'(CRC_OFFSET + 2);

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [CRC_W-1:0]   crc_accum, crc_accum_next;
  logic [2:0]         size_code, size_code_next;
  logic [7:0]         type_byte, type_byte_next;
  logic [CRC_W-1:0]   held_crc, held_crc_next;
  logic [COUNT_W-1:0] expect_len;
  err_code_t          code;

  always_comb begin
    byte_count_next = byte_count;
    crc_accum_next  = crc_accum;
    size_code_next  = size_code;
    type_byte_next  = type_byte;
    held_crc_next   = held_crc;
    if (byte_count < COUNT_SAT) begin
      if (byte_count == '0) begin
        size_code_next = data_byte[6:4];
      end
      if (byte_count == TYPE_POS) begin
        type_byte_next = data_byte;
      end
      if (byte_count < CRC_POS) begin
        crc_accum_next = crc_byte(crc_accum, data_byte);
      end
      if (byte_count == CRC_POS) begin
        held_crc_next = {held_crc[15:8], data_byte};
      end
      if (byte_count == CRC_HI) begin
        held_crc_next = {data_byte, held_crc[7:0]};
      end
      byte_count_next = byte_count + 1'b1;
    end
  end

  // image length that each size code calls for; zero marks an invalid code
  always_comb begin
    case (size_code_next)
      3'd1:    expect_len = 11'd256;
      3'd2:    expect_len = 11'd512;
      3'd3:    expect_len = 11'd1024;
      default: expect_len = '0;
    endcase
  end

  always_comb begin
    if (byte_count_next < min_size) begin
      code = ERR_SIZE;
    end else if (expect_len == '0 || byte_count_next != expect_len) begin
      code = ERR_SIZE;
    end else if (type_byte_next != ddr5_type_code) begin
      code = ERR_TYPE;
    end else if (byte_count_next < CRC_END) begin
      code = ERR_CRC_SHORT;
    end else if (crc_accum_next != held_crc_next) begin
      code = ERR_CRC_MISS;
    end else begin
      code = ERR_NONE;
    end
  end

  assign verdict.image_ok     = (code == ERR_NONE);
  assign verdict.error_code   = code;
  assign verdict.computed_crc = crc_accum_next;

  always_ff @(posedge clk) begin
    if (rst || (take && last)) begin
      byte_count <= '0;
      crc_accum  <= '0;
      size_code  <= '0;
      type_byte  <= '0;
      held_crc   <= '0;
    end else if (take) begin
      byte_count <= byte_count_next;
      crc_accum  <= crc_accum_next;
      size_code  <= size_code_next;
      type_byte  <= type_byte_next;
      held_crc   <= held_crc_next;
    end
  end

endmodule

`default_nettype wire

### rtl/spdcrc_skid.sv
// result register with one skid entry so the byte side stalls only when
// both are full; uses spdcrc_pkg
`default_nettype none

module spdcrc_skid (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  spdcrc_pkg::result_t  push_data,
  output logic                 full,
  output logic                 out_valid,
  input  wire                  out_stall,
  output spdcrc_pkg::result_t  out_data
);
  import spdcrc_pkg::*;

  logic    skid_valid;
  result_t skid_data;
  logic    out_take;

  assign out_take = out_valid && !out_stall;
  assign full     = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || out_take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_take) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || out_take) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/spd_image_crc_validator.sv
// spd image checker: one byte per cycle while in_stall is low; the verdict on
// the byte marked last comes from the byte-wide crc update and checks
// between the image state registers and the result register.
// the result side has a register plus one skid entry; input stalls only when
// both hold undelivered verdicts. synchronous reset clears the image state and
// the result side, and sets min_size to 256 and ddr5_type_code to 18.
`default_nettype none

module spd_image_crc_validator #(
  parameter int TYPE_OFFSET = 2,
  parameter int CRC_OFFSET  = 510
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [7:0]  data_byte,
  input  wire         last,
  output logic        out_valid,
  input  wire         out_stall,
  output logic        image_ok,
  output logic [2:0]  error_code,
  output logic [15:0] computed_crc,
  input  wire         cfg_we,
  input  wire  [0:0]  cfg_index,
  input  wire  [10:0] cfg_data
);
  import spdcrc_pkg::*;

  logic [CFG_W-1:0] min_size;
  logic [7:0]       ddr5_type_code;
  logic             take;
  logic             skid_full;
  result_t          verdict;
  result_t          result;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_size       <= MIN_SIZE_RST;
      ddr5_type_code <= DDR5_TYPE_RST;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_MIN_SIZE:  min_size       <= cfg_data;
        REG_DDR5_TYPE: ddr5_type_code <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign in_stall = skid_full;
  assign take     = in_valid && !in_stall;

  spdcrc_accum #(
    .TYPE_OFFSET(TYPE_OFFSET),
    .CRC_OFFSET (CRC_OFFSET)
  ) u_accum (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .data_byte     (data_byte),
    .last          (last),
    .min_size      (min_size),
    .ddr5_type_code(ddr5_type_code),
    .verdict       (verdict)
  );

  spdcrc_skid u_skid (
    .clk      (clk),
    .rst      (rst),
    .push     (take && last),
    .push_data(verdict),
    .full     (skid_full),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (result)
  );

  assign image_ok     = result.image_ok;
  assign error_code   = result.error_code;
  assign computed_crc = result.computed_crc;

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// self-checking bench for spd_image_crc_validator: streams spd images byte by byte
// and checks every verdict against a local crc-16 and length/type predictor
// depends on rtl/spdcrc_pkg.sv and rtl/spd_image_crc_validator.sv
`default_nettype none

module testbench;
  import spdcrc_pkg::*;

  localparam int TYPE_OFS      = 2;
  localparam int CRC_OFS       = 510;
  localparam int IMG_COUNT_MAX = 1025;
  localparam logic [15:0] CRC16_POLY = 16'h1021;
  localparam int HOLD_CYCLES   = 64;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 4;

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } stream_byte_t;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_LIGHT,
    RX_HEAVY,
    RX_TOGGLE
  } rx_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        image_ok;
  logic [2:0]  error_code;
  logic [15:0] computed_crc;
  logic        cfg_we = 1'b0;
  reg_index_t  cfg_index = REG_MIN_SIZE;
  logic [10:0] cfg_data = '0;

  // predictor copy of the image state and the registers
  logic [10:0] img_count = '0;
  logic [15:0] img_crc = '0;
  logic [2:0]  img_size_code = '0;
  logic [7:0]  img_type = '0;
  logic [15:0] img_file_crc = '0;
  logic [10:0] min_len_cfg = 11'd256;
  logic [7:0]  ddr5_type_cfg = 8'd18;

  stream_byte_t pending_bytes[$];
  stream_byte_t next_byte;
  result_t      verdict_q[$];
  result_t      want;

  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  int holds_asked = 0;
  int holds_granted = 0;
  int rx_tick = 0;
  rx_mode_t rx_mode = RX_FREE;
  int idle_cycles = 0;
  int mismatch_count = 0;
  int verdicts_seen = 0;

  spd_image_crc_validator #(
    .TYPE_OFFSET(TYPE_OFS),
    .CRC_OFFSET(CRC_OFS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .last(last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .image_ok(image_ok),
    .error_code(error_code),
    .computed_crc(computed_crc),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // bit-serial xmodem crc, msb of the byte first
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0} ^ (fb ? CRC16_POLY : 16'h0000);
    end
    return r;
  endfunction

  // append one byte to the sender's queue
  function automatic void queue_byte(input logic [7:0] b, input logic is_last);
    stream_byte_t sb;
    sb.value = b;
    sb.is_last = is_last;
    pending_bytes.insert(pending_bytes.size(), sb);
  endfunction

  // fold one accepted byte into the image state, queue a verdict on the last one
  function automatic void absorb_byte(input logic [7:0] b, input logic is_last);
    result_t v;
    err_code_t code;
    int len;
    if (img_count < IMG_COUNT_MAX) begin
      if (img_count == 0) img_size_code = b[6:4];
      if (img_count == TYPE_OFS) img_type = b;
      if (img_count < CRC_OFS) img_crc = crc16_next(img_crc, b);
      if (img_count == CRC_OFS) img_file_crc[7:0] = b;
      if (img_count == CRC_OFS + 1) img_file_crc[15:8] = b;
      img_count = img_count + 11'd1;
    end
    if (is_last) begin
      len = int'(img_count);
      if (len < int'(min_len_cfg)) begin
        code = ERR_SIZE;
      end else if (img_size_code < 1 || img_size_code > 3 || len != (128 << img_size_code)) begin
        code = ERR_SIZE;
      end else if (img_type != ddr5_type_cfg) begin
        code = ERR_TYPE;
      end else if (len < CRC_OFS + 2) begin
        code = ERR_CRC_SHORT;
      end else if (img_crc != img_file_crc) begin
        code = ERR_CRC_MISS;
      end else begin
        code = ERR_NONE;
      end
      v.image_ok = (code == ERR_NONE);
      v.error_code = code;
      v.computed_crc = img_crc;
      verdict_q.insert(verdict_q.size(), v);
      img_count = '0;
      img_crc = '0;
      img_size_code = '0;
      img_type = '0;
      img_file_crc = '0;
    end
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch: %s", msg);
  endtask

  // random image with a chosen size code and type byte; the stored crc is
  // filled in (right or with one bit flipped) when the image is long enough
  task automatic push_image(input int len, input logic [2:0] sc, input logic [7:0] tbyte,
                            input bit crc_good);
    logic [7:0] img [];
    logic [15:0] crc;
    img = new[len];
    foreach (img[i]) img[i] = 8'($urandom);
    img[0][6:4] = sc;
    if (len > TYPE_OFS) img[TYPE_OFS] = tbyte;
    if (len > CRC_OFS + 1) begin
      crc = '0;
      for (int i = 0; i < CRC_OFS; i++) crc = crc16_next(crc, img[i]);
      if (!crc_good) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
      img[CRC_OFS] = crc[7:0];
      img[CRC_OFS + 1] = crc[15:8];
    end
    foreach (img[i]) queue_byte(img[i], (i == len - 1));
  endtask

  // short image with any size code, type byte right about half the time
  task automatic push_random_image();
    logic [7:0] typ;
    typ = ($urandom_range(0, 1) == 0) ? ddr5_type_cfg : 8'($urandom);
    push_image($urandom_range(1, 8), 3'($urandom), typ, 1'b1);
  endtask

  // wait until every queued byte is sent and every verdict is back
  task automatic drain();
    @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || verdict_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [10:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MIN_SIZE) begin
      min_len_cfg = val;
    end else begin
      ddr5_type_cfg = val[7:0];
    end
  endtask

  task automatic run_phase(input int images);
    repeat (images) push_random_image();
    drain();
  endtask

  // sender: bursts of transfers separated by random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) absorb_byte(data_byte, last);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          next_byte = pending_bytes.pop_front();
          in_valid <= 1'b1;
          data_byte <= next_byte.value;
          last <= next_byte.is_last;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern picked at random from four modes, plus requested long holds
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      holds_granted <= 0;
      rx_tick <= 0;
      rx_mode <= RX_FREE;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_granted != holds_asked) begin
      holds_granted <= holds_granted + 1;
      hold_left <= HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      rx_tick <= rx_tick + 1;
      if (rx_tick % 64 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_FREE: begin
          out_stall <= 1'b0;
        end
        RX_LIGHT: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        RX_HEAVY: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
        default: begin
          out_stall <= rx_tick[1];
        end
      endcase
    end
  end

  // verdict checker
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      verdicts_seen++;
      if (verdict_q.size() == 0) begin
        flag_mismatch($sformatf("verdict %0d arrived with none pending: ok=%0b err=%0d crc=%04h",
                                verdicts_seen, image_ok, error_code, computed_crc));
      end else begin
        want = verdict_q.pop_front();
        if (image_ok !== want.image_ok || error_code !== want.error_code ||
            computed_crc !== want.computed_crc) begin
          flag_mismatch($sformatf({"verdict %0d: expected ok=%0b err=%0d crc=%04h, ",
                                   "got ok=%0b err=%0d crc=%04h"}, verdicts_seen,
                                  want.image_ok, want.error_code, want.computed_crc,
                                  image_ok, error_code, computed_crc));
        end
      end
    end
  end

  // no-progress watchdog
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: one-byte images at the byte extremes, then short images carrying
    // a size code and, all but the last, a type byte, under reset register values
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hff, 1'b1);
    queue_byte(8'h20, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'h12, 1'b1);
    queue_byte(8'ha5, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hff, 1'b0);
    queue_byte(8'h7f, 1'b1);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b1);
    drain();

    run_phase(4);

    // shortest legal length: too short for the stored crc, or a type mismatch
    push_image(256, 3'd1, ($urandom_range(0, 3) != 0) ? ddr5_type_cfg : 8'($urandom), 1'b1);
    drain();

    // long receiver hold while one-byte images keep coming, so the block backs up
    holds_asked++;
    repeat (12) queue_byte(8'($urandom), 1'b1);
    drain();

    // low extremes; upper data bits on the type write are don't-care
    write_reg(REG_MIN_SIZE, 11'd0);
    write_reg(REG_DDR5_TYPE, {3'($urandom), 8'h00});
    run_phase(4);

    write_reg(REG_MIN_SIZE, 11'd1024);
    write_reg(REG_DDR5_TYPE, {3'($urandom), 8'hff});
    holds_asked++;
    run_phase(4);

    write_reg(REG_MIN_SIZE, 11'd512);
    write_reg(REG_DDR5_TYPE, 11'd18);
    // 512-byte image that reaches the crc compare, stored crc right or corrupted
    push_image(512, 3'd2, ddr5_type_cfg, $urandom_range(0, 1) != 0);
    run_phase(2);

    write_reg(REG_MIN_SIZE, 11'($urandom_range(0, 1024)));
    write_reg(REG_DDR5_TYPE, 11'($urandom));
    run_phase(4);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

### spd_image_crc_validator.f
rtl/spdcrc_pkg.sv
rtl/spdcrc_accum.sv
rtl/spdcrc_skid.sv
rtl/spd_image_crc_validator.sv
tb/sv/testbench.sv
